// ----- rtl/core/dense_layer_forward_top_macros.svh -----
// Assertion macros for the dense layer block.
// DLF_ASSERT checks on every clock edge outside reset.
// DLF_ASSERT_ALWAYS checks on every clock edge, reset included.
`ifndef DENSE_LAYER_FORWARD_TOP_MACROS_SVH
`define DENSE_LAYER_FORWARD_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define DLF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dense layer check failed");
`define DLF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dense layer check failed");
`else
`define DLF_ASSERT(lbl, prop)
`define DLF_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ----- rtl/core/dlf_pkg.sv -----
package dlf_pkg;

  localparam int NEURONS_DEF    = 16;
  localparam int MAX_INPUTS_DEF = 1024;

  localparam int DATA_W = 16;
  localparam int PROD_W = 32;
  localparam int ACC_W  = 48;
  localparam int NIU_W  = 5;

  localparam logic [NIU_W-1:0] NIU_RESET = 5'd16;

  typedef enum logic {
    MODE_WEIGHT = 1'b0,
    MODE_DATA   = 1'b1
  } mode_t;

  typedef enum logic {
    REG_ACT_SEL = 1'b0,
    REG_NIU     = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_MAC_END,
    ST_EMIT,
    ST_EMIT_END
  } state_t;

  typedef struct packed {
    logic               mode;
    logic [3:0]         neuron;
    logic [9:0]         weight_position;
    logic signed [15:0] value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         neuron_index;
    logic signed [15:0] pre_activation;
    logic signed [15:0] activation;
    logic               final_neuron;
  } out_item_t;

  // Round Q24.24 to Q4.12 (add half, floor) and saturate to 16 bits.
  function automatic logic signed [15:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W:0]    s;
    logic signed [ACC_W-12:0] q;
    s = {acc[ACC_W-1], acc} + (ACC_W+1)'(2048);
    q = s[ACC_W:12];
    if (q < -(ACC_W-11)'(32768)) begin
      return -16'sd32768;
    end else if (q > (ACC_W-11)'(32767)) begin
      return 16'sd32767;
    end else begin
      return q[15:0];
    end
  endfunction

  // Piecewise-linear sigmoid on Q4.12, mirrored for negative inputs.
  function automatic logic signed [15:0] sigmoid_pwl(input logic signed [15:0] x);
    logic signed [16:0] xe;
    logic [16:0]        a;
    logic [12:0]        y;
    logic [12:0]        r;
    xe = {x[15], x};
    a  = xe[16] ? unsigned'(-xe) : unsigned'(xe);
    if (a >= 17'd20480) begin
      y = 13'd4096;
    end else if (a >= 17'd9728) begin
      y = 13'((a >> 5) + 17'd3456);
    end else if (a >= 17'd4096) begin
      y = 13'((a >> 3) + 17'd2560);
    end else begin
      y = 13'((a >> 2) + 17'd2048);
    end
    r = x[15] ? 13'(13'd4096 - y) : y;
    return signed'({3'b000, r});
  endfunction

endpackage

// ----- rtl/core/dense_layer_forward_top.sv -----
// Dense layer forward pass, signed Q4.12. A transaction with mode = weight
// stores one weight at (neuron, weight_position); weights out of range are
// dropped. A transaction with mode = data carries one input element: the
// block walks the active neurons through one shared multiply-accumulate
// unit, reading each weight and each 48-bit accumulator from on-chip memory
// and writing the sum back; busy stays high until every sum is written, and
// only then is the next element taken. On an element with last set the block
// then streams n results (n = active neurons) in neuron order, one per cycle
// on out_strobe, each rounded into a register and passed through the
// activation into the output register, final_neuron marking the last; busy
// stays high until the burst is out. The receiver cannot stall: every
// result is valid for exactly one cycle and must be captured then. Weights
// are not cleared by reset and must be written before use; accumulators
// and the input position clear by reset and after every result burst.
// Registers (APB, 32-bit): 0x0 activation select (0 ReLU, 1 sigmoid),
// 0x4 neurons in use (0 acts as 1, above NEURONS acts as NEURONS).
`include "dense_layer_forward_top_macros.svh"

module dense_layer_forward_top #(
  parameter int NEURONS    = dlf_pkg::NEURONS_DEF,
  parameter int MAX_INPUTS = dlf_pkg::MAX_INPUTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  dlf_pkg::in_item_t   in_item,
  output logic                out_strobe,
  output dlf_pkg::out_item_t  out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import dlf_pkg::*;

  localparam int NW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int PW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int CW = $clog2(MAX_INPUTS + 1);
  localparam int WDEPTH = NEURONS << PW;

  // Configuration registers.
  logic             act_sel_r;
  logic [NIU_W-1:0] niu_r;
  logic             cfg_we;

  // Sequencer.
  state_t         state_r, state_nxt;
  logic [NW-1:0]  k_r, k_nxt;
  logic [NW-1:0]  last_k;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic signed [DATA_W-1:0] x_r;
  logic           last_r;
  logic           accept;
  logic           mac_issue;
  logic           emit_issue;
  logic           clear_acc;

  // Memories.
  logic [DATA_W-1:0] wmem [WDEPTH];
  logic [ACC_W-1:0]  amem [NEURONS];
  logic              w_we;
  logic [NW+PW-1:0]  w_waddr;
  logic [NW+PW-1:0]  w_raddr;
  logic [DATA_W-1:0] w_rd_r;
  logic [NW-1:0]     a_raddr;
  logic [ACC_W-1:0]  acc_rd_r;
  logic [NEURONS-1:0] acc_vld_r;
  logic [7:0]        nrn_ext;
  logic [15:0]       pos_ext;

  // Accumulate pipeline.
  logic              p1_vld_r, p2_vld_r;
  logic [NW-1:0]     p1_k_r, p2_k_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_old;
  logic signed [ACC_W-1:0]  acc_sum;
  logic              acc_we;

  // Result pipeline.
  logic              e1_vld_r, e2_vld_r;
  logic [NW-1:0]     e1_k_r, e2_k_r;
  logic              e1_fin_r, e2_fin_r;
  logic signed [ACC_W-1:0]  emit_acc;
  logic signed [15:0] pre_r;
  logic signed [15:0] act_val;
  logic [7:0]        e2_k_ext;
  logic              out_strobe_r;
  out_item_t         out_item_r;

  // ---------------------------------------------------------------------
  // APB register file: paddr[2] selects the register, writes always ready.
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_sel_r <= 1'b0;
      niu_r     <= NIU_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(paddr[2]))
        REG_ACT_SEL: act_sel_r <= pwdata[0];
        REG_NIU:     niu_r     <= pwdata[NIU_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[2]))
      REG_ACT_SEL: prdata = {31'd0, act_sel_r};
      REG_NIU:     prdata = {{(32-NIU_W){1'b0}}, niu_r};
      default:     prdata = '0;
    endcase
  end

  // Index of the last active neuron; clamp zero to one and cap at NEURONS.
  always_comb begin
    if (niu_r == '0) begin
      last_k = '0;
    end else if (32'(niu_r) > NEURONS) begin
      last_k = NW'(NEURONS - 1);
    end else begin
      last_k = NW'(niu_r - NIU_W'(1));
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer: next state.
  // ---------------------------------------------------------------------
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (mode_t'(in_item.mode) == MODE_DATA)) begin
          if (cnt_r < CW'(MAX_INPUTS)) begin
            state_nxt = ST_MAC;
          end else if (in_item.last) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_MAC: begin
        if (k_r == last_k) begin
          state_nxt = ST_MAC_END;
        end
      end
      ST_MAC_END: begin
        if (!p1_vld_r && !p2_vld_r) begin
          state_nxt = last_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (k_r == last_k) begin
          state_nxt = ST_EMIT_END;
        end
      end
      ST_EMIT_END: begin
        if (!e1_vld_r && !e2_vld_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    busy       = 1'b1;
    mac_issue  = 1'b0;
    emit_issue = 1'b0;
    clear_acc  = 1'b0;
    unique case (state_r)
      ST_IDLE:     busy       = 1'b0;
      ST_MAC:      mac_issue  = 1'b1;
      ST_MAC_END:  ;
      ST_EMIT:     emit_issue = 1'b1;
      ST_EMIT_END: clear_acc  = !e1_vld_r && !e2_vld_r;
      default:     ;
    endcase
  end

  // Neuron counter and input position.
  always_comb begin
    k_nxt   = k_r;
    cnt_nxt = cnt_r;
    if (mac_issue || emit_issue) begin
      k_nxt = (k_r == last_k) ? '0 : NW'(k_r + NW'(1));
    end
    // Advance the position once all neurons of this element are written.
    if ((state_r == ST_MAC_END) && !p1_vld_r && !p2_vld_r) begin
      cnt_nxt = CW'(cnt_r + CW'(1));
    end
    if (clear_acc) begin
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Hold the element and its last mark for the whole pass.
  always_ff @(posedge clk) begin
    if (accept && (mode_t'(in_item.mode) == MODE_DATA)) begin
      x_r    <= in_item.value;
      last_r <= in_item.last;
    end
  end

  // ---------------------------------------------------------------------
  // Weight memory: {neuron, position}, written only while idle.
  // ---------------------------------------------------------------------
  assign nrn_ext = 8'(in_item.neuron);
  assign pos_ext = 16'(in_item.weight_position);
  assign w_waddr = {nrn_ext[NW-1:0], pos_ext[PW-1:0]};
  assign w_raddr = {k_r, cnt_r[PW-1:0]};
  assign w_we    = accept && (mode_t'(in_item.mode) == MODE_WEIGHT) &&
                   (32'(in_item.neuron) < NEURONS) &&
                   (32'(in_item.weight_position) < MAX_INPUTS);

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_waddr] <= in_item.value;
    end
    w_rd_r <= wmem[w_raddr];
  end

  // ---------------------------------------------------------------------
  // Accumulator memory: read at the product stage, written back one later.
  // An entry without its valid bit reads as zero.
  // ---------------------------------------------------------------------
  assign a_raddr = emit_issue ? k_r : p1_k_r;
  assign acc_we  = p2_vld_r;
  assign acc_old = acc_vld_r[p2_k_r] ? signed'(acc_rd_r) : '0;
  assign acc_sum = acc_old + ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    if (acc_we) begin
      amem[p2_k_r] <= acc_sum;
    end
    acc_rd_r <= amem[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r <= '0;
    end else if (clear_acc) begin
      acc_vld_r <= '0;
    end else if (acc_we) begin
      acc_vld_r[p2_k_r] <= 1'b1;
    end
  end

  // Multiply stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= mac_issue;
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_k_r <= k_r;
    p2_k_r <= p1_k_r;
    prod_r <= PROD_W'(x_r) * PROD_W'(signed'(w_rd_r));
  end

  // ---------------------------------------------------------------------
  // Result stream: round and saturate, then activation into the output
  // register.
  // ---------------------------------------------------------------------
  assign emit_acc = acc_vld_r[e1_k_r] ? signed'(acc_rd_r) : '0;
  assign act_val  = act_sel_r ? sigmoid_pwl(pre_r) :
                    (pre_r[15] ? 16'sd0 : pre_r);
  assign e2_k_ext = 8'(e2_k_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_vld_r     <= 1'b0;
      e2_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      e1_vld_r     <= emit_issue;
      e2_vld_r     <= e1_vld_r;
      out_strobe_r <= e2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    e1_k_r   <= k_r;
    e1_fin_r <= (k_r == last_k);
    e2_k_r   <= e1_k_r;
    e2_fin_r <= e1_fin_r;
    pre_r    <= round_sat(emit_acc);
    out_item_r.neuron_index   <= e2_k_ext[3:0];
    out_item_r.pre_activation <= pre_r;
    out_item_r.activation     <= act_val;
    out_item_r.final_neuron   <= e2_fin_r;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // ---------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------
  `DLF_ASSERT(a_final_ends_burst, out_strobe && out_item.final_neuron |=> !out_strobe)
  `DLF_ASSERT(a_strobe_while_busy, out_strobe |-> busy)
  `DLF_ASSERT(a_no_acc_write_in_emit, acc_we |-> !emit_issue && !e1_vld_r)
  `DLF_ASSERT_ALWAYS(a_wmem_single_port, !(w_we && mac_issue))

endmodule
